FILE: hw/rtl/ftsd_pkg.sv
// Package for the file transfer stream deframer: payload structs, codes,
// parser phases and the text marker table. Depends on nothing.

package ftsd_pkg;

  localparam int unsigned MaxNameBytesDefault = 256;
  localparam int unsigned IndexWidthDefault   = 16;
  localparam int unsigned MarkLen             = 18;

  // Input kind codes.
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_CLOSE  = 2'd2,
    KIND_UNUSED = 2'd3
  } in_kind_e;

  // Operation decoded by the front end.
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_NAME   = 3'd2,
    PH_SIZE   = 3'd3,
    PH_DATA   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CLS_HEADER   = 3'd0,
    CLS_NAME     = 3'd1,
    CLS_NAME_END = 3'd2,
    CLS_SIZE     = 3'd3,
    CLS_DATA     = 3'd4,
    CLS_IGNORED  = 3'd5,
    CLS_EVENT    = 3'd6
  } byte_class_e;

  typedef enum logic [1:0] {
    EK_FOLDER = 2'd0,
    EK_FILE   = 2'd1,
    EK_TEXT   = 2'd2
  } elem_kind_e;

  typedef enum logic [1:0] {
    CS_COMPLETE  = 2'd0,
    CS_TEXT      = 2'd1,
    CS_CANCELLED = 2'd2,
    CS_NONE      = 2'd3
  } close_status_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
  } op_item_t;

  typedef struct packed {
    logic [2:0]         byte_class;
    logic [7:0]         byte_out;
    logic [15:0]        element_index;
    logic [1:0]         element_kind;
    logic signed [63:0] element_size;
    logic               element_done;
    logic [62:0]        announced_count;
    logic [62:0]        announced_total;
    logic [62:0]        received_total;
    logic [1:0]         close_status;
    logic               error_flag;
  } out_item_t;

  // Characters of the text marker name, by position.
  function automatic logic [7:0] mark_byte(input logic [4:0] pos);
    logic [7:0] c;
    case (pos)
      5'd3:    c = 8'h44;
      5'd4:    c = 8'h55;
      5'd5:    c = 8'h4B;
      5'd6:    c = 8'h54;
      5'd7:    c = 8'h4F;
      5'd11:   c = 8'h54;
      5'd12:   c = 8'h45;
      5'd13:   c = 8'h58;
      5'd14:   c = 8'h54;
      default: c = 8'h5F;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/ftsd_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// The payload type is set per instance; no package dependency.

interface ftsd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/ftsd_front.sv
// Front end: accepts input words, decodes their kind into an operation and
// holds them in a register stage ahead of the queue. Uses ftsd_pkg.

module ftsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ftsd_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ftsd_pkg::op_item_t item_o
);

  logic               valid_q;
  ftsd_pkg::op_item_t item_q;
  ftsd_pkg::op_item_t item_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    item_d.byte_value = item_i.byte_value;
    unique case (ftsd_pkg::in_kind_e'(item_i.kind))
      ftsd_pkg::KIND_DATA:  item_d.op = ftsd_pkg::OP_BYTE;
      ftsd_pkg::KIND_OPEN:  item_d.op = ftsd_pkg::OP_OPEN;
      ftsd_pkg::KIND_CLOSE: item_d.op = ftsd_pkg::OP_CLOSE;
      default:              item_d.op = ftsd_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/ftsd_queue.sv
// Two-entry queue between the front end and the parser, so that either
// side can stall on its own. Uses ftsd_pkg.

module ftsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  ftsd_pkg::op_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output ftsd_pkg::op_item_t pop_item_o
);

  ftsd_pkg::op_item_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/ftsd_back.sv
// Parser back end: walks the header, names, sizes and data of the stream,
// one word per cycle while its output is free, and holds each result in an
// output register. Uses ftsd_pkg.

module ftsd_back #(
  parameter int unsigned MAX_NAME_BYTES = ftsd_pkg::MaxNameBytesDefault,
  parameter int unsigned INDEX_WIDTH    = ftsd_pkg::IndexWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  ftsd_pkg::op_item_t  item_i,
  output logic                valid_o,
  input  logic                ready_i,
  output ftsd_pkg::out_item_t item_o
);

  localparam int unsigned NameW = $clog2(MAX_NAME_BYTES + 1);

  // Parser state.
  ftsd_pkg::phase_e     phase_q, phase_d;
  logic [3:0]           hdr_cnt_q, hdr_cnt_d;
  logic [63:0]          hdr_count_q, hdr_count_d;
  logic [63:0]          hdr_total_q, hdr_total_d;
  logic [NameW-1:0]     name_len_q, name_len_d;
  logic                 mark_match_q, mark_match_d;
  logic [2:0]           size_cnt_q, size_cnt_d;
  logic [63:0]          size_q, size_d;
  logic [63:0]          remain_q, remain_d;
  logic [62:0]          rx_total_q, rx_total_d;
  logic [INDEX_WIDTH-1:0] elem_cnt_q, elem_cnt_d;
  ftsd_pkg::elem_kind_e kind_q, kind_d;
  logic                 file_open_q, file_open_d;
  logic                 text_mode_q, text_mode_d;

  // Output register.
  logic                valid_q;
  ftsd_pkg::out_item_t out_q;
  ftsd_pkg::out_item_t out_d;

  logic pop;
  logic is_byte, is_open, is_close;
  logic [7:0] b;
  logic hdr_last, name_nul, name_long, size_last;
  logic [63:0] size_new;
  logic size_folder, size_neg, size_zero, is_text, data_last;
  logic [INDEX_WIDTH-1:0]  idx_sel;
  logic [INDEX_WIDTH+15:0] idx_ext;
  ftsd_pkg::byte_class_e   cls;
  ftsd_pkg::close_status_e cstat;
  logic done, err;

  assign ready_o  = !valid_q || ready_i;
  assign pop      = valid_i && ready_o;
  assign b        = item_i.byte_value;
  assign is_byte  = pop && (item_i.op == ftsd_pkg::OP_BYTE);
  assign is_open  = pop && (item_i.op == ftsd_pkg::OP_OPEN);
  assign is_close = pop && (item_i.op == ftsd_pkg::OP_CLOSE);

  assign hdr_last  = (hdr_cnt_q == 4'd15);
  assign name_nul  = (b == 8'd0);
  assign name_long = (name_len_q >= NameW'(MAX_NAME_BYTES));
  assign size_last = (size_cnt_q == 3'd7);
  assign is_text   = mark_match_q && (name_len_q == NameW'(ftsd_pkg::MarkLen));

  // The size as it stands once this byte is merged into its lane.
  always_comb begin
    size_new = size_q;
    for (int i = 0; i < 8; i++) begin
      if (size_cnt_q == 3'(i)) size_new[8*i +: 8] = b;
    end
  end

  assign size_folder = &size_new;
  assign size_neg    = size_new[63];
  assign size_zero   = (size_new == 64'd0);
  // Any data byte that brings the remaining count to zero ends the element.
  assign data_last   = (remain_q[63:1] == 63'd0);

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    if (is_open) begin
      phase_d = ftsd_pkg::PH_HEADER;
    end else if (is_close) begin
      phase_d = ftsd_pkg::PH_IDLE;
    end else if (is_byte) begin
      unique case (phase_q)
        ftsd_pkg::PH_HEADER: begin
          if (hdr_last) phase_d = ftsd_pkg::PH_NAME;
        end
        ftsd_pkg::PH_NAME: begin
          if (name_nul) begin
            phase_d = ftsd_pkg::PH_SIZE;
          end else if (name_long) begin
            phase_d = ftsd_pkg::PH_ERROR;
          end
        end
        ftsd_pkg::PH_SIZE: begin
          if (size_last) begin
            if (size_folder || size_zero) begin
              phase_d = ftsd_pkg::PH_NAME;
            end else if (size_neg) begin
              phase_d = ftsd_pkg::PH_ERROR;
            end else begin
              phase_d = ftsd_pkg::PH_DATA;
            end
          end
        end
        ftsd_pkg::PH_DATA: begin
          if (data_last) phase_d = ftsd_pkg::PH_NAME;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Datapath and result fields.
  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    hdr_count_d  = hdr_count_q;
    hdr_total_d  = hdr_total_q;
    name_len_d   = name_len_q;
    mark_match_d = mark_match_q;
    size_cnt_d   = size_cnt_q;
    size_d       = size_q;
    remain_d     = remain_q;
    rx_total_d   = rx_total_q;
    elem_cnt_d   = elem_cnt_q;
    kind_d       = kind_q;
    file_open_d  = file_open_q;
    text_mode_d  = text_mode_q;
    cls          = ftsd_pkg::CLS_IGNORED;
    cstat        = ftsd_pkg::CS_NONE;
    done         = 1'b0;
    err          = 1'b0;
    idx_sel      = elem_cnt_q;

    if (is_open || is_close) begin
      cls          = ftsd_pkg::CLS_EVENT;
      hdr_cnt_d    = '0;
      hdr_count_d  = '0;
      hdr_total_d  = '0;
      name_len_d   = '0;
      mark_match_d = 1'b1;
      size_cnt_d   = '0;
      size_d       = '0;
      remain_d     = '0;
      rx_total_d   = '0;
      elem_cnt_d   = '0;
      kind_d       = ftsd_pkg::EK_FOLDER;
      file_open_d  = 1'b0;
      text_mode_d  = 1'b0;
      if (is_open) idx_sel = '0;
      if (is_close) begin
        if (phase_q == ftsd_pkg::PH_IDLE) begin
          cstat = ftsd_pkg::CS_NONE;
        end else if (phase_q == ftsd_pkg::PH_ERROR || file_open_q) begin
          cstat = ftsd_pkg::CS_CANCELLED;
        end else if (text_mode_q) begin
          cstat = ftsd_pkg::CS_TEXT;
        end else begin
          cstat = ftsd_pkg::CS_COMPLETE;
        end
      end
    end else if (is_byte) begin
      case (phase_q)
        ftsd_pkg::PH_HEADER: begin
          cls = ftsd_pkg::CLS_HEADER;
          for (int i = 0; i < 8; i++) begin
            if (hdr_cnt_q[2:0] == 3'(i)) begin
              if (hdr_cnt_q[3]) hdr_total_d[8*i +: 8] = b;
              else              hdr_count_d[8*i +: 8] = b;
            end
          end
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (hdr_last) begin
            name_len_d   = '0;
            mark_match_d = 1'b1;
          end
        end
        ftsd_pkg::PH_NAME: begin
          if (name_nul) begin
            cls = ftsd_pkg::CLS_NAME_END;
            if (!is_text) mark_match_d = 1'b0;
            size_cnt_d = '0;
            size_d     = '0;
          end else if (name_long) begin
            err = 1'b1;
          end else begin
            cls = ftsd_pkg::CLS_NAME;
            if (name_len_q >= NameW'(ftsd_pkg::MarkLen)
                || ftsd_pkg::mark_byte(name_len_q[4:0]) != b) begin
              mark_match_d = 1'b0;
            end
            name_len_d = name_len_q + NameW'(1);
          end
        end
        ftsd_pkg::PH_SIZE: begin
          cls        = ftsd_pkg::CLS_SIZE;
          size_d     = size_new;
          size_cnt_d = size_cnt_q + 3'd1;
          if (size_last) begin
            name_len_d   = '0;
            mark_match_d = 1'b1;
            if (size_folder) begin
              kind_d     = ftsd_pkg::EK_FOLDER;
              done       = 1'b1;
              elem_cnt_d = elem_cnt_q + INDEX_WIDTH'(1);
            end else if (size_neg) begin
              err = 1'b1;
            end else begin
              kind_d      = is_text ? ftsd_pkg::EK_TEXT : ftsd_pkg::EK_FILE;
              text_mode_d = is_text;
              if (size_zero) begin
                file_open_d = 1'b0;
                done        = 1'b1;
                elem_cnt_d  = elem_cnt_q + INDEX_WIDTH'(1);
              end else begin
                file_open_d = !is_text;
                remain_d    = size_new;
              end
            end
          end
        end
        ftsd_pkg::PH_DATA: begin
          cls = ftsd_pkg::CLS_DATA;
          if (!(&rx_total_q)) rx_total_d = rx_total_q + 63'd1;
          if (remain_q != 64'd0) remain_d = remain_q - 64'd1;
          if (data_last) begin
            done         = 1'b1;
            file_open_d  = 1'b0;
            elem_cnt_d   = elem_cnt_q + INDEX_WIDTH'(1);
            name_len_d   = '0;
            mark_match_d = 1'b1;
          end
        end
        default: cls = ftsd_pkg::CLS_IGNORED;
      endcase
    end

    idx_ext = {16'd0, idx_sel};

    // A close reports the kind, size and totals it finds; everything else
    // reports those it leaves behind.
    out_d.byte_class    = cls;
    out_d.byte_out      = b;
    out_d.element_index = idx_ext[15:0];
    out_d.element_done  = done;
    out_d.close_status  = cstat;
    out_d.error_flag    = err;
    if (is_close) begin
      out_d.element_kind    = kind_q;
      out_d.element_size    = size_q;
      out_d.announced_count = hdr_count_q[62:0];
      out_d.announced_total = hdr_total_q[62:0];
      out_d.received_total  = rx_total_q;
    end else begin
      out_d.element_kind    = kind_d;
      out_d.element_size    = size_d;
      out_d.announced_count = hdr_count_d[62:0];
      out_d.announced_total = hdr_total_d[62:0];
      out_d.received_total  = rx_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ftsd_pkg::PH_IDLE;
      hdr_cnt_q    <= '0;
      hdr_count_q  <= '0;
      hdr_total_q  <= '0;
      name_len_q   <= '0;
      mark_match_q <= 1'b1;
      size_cnt_q   <= '0;
      size_q       <= '0;
      remain_q     <= '0;
      rx_total_q   <= '0;
      elem_cnt_q   <= '0;
      kind_q       <= ftsd_pkg::EK_FOLDER;
      file_open_q  <= 1'b0;
      text_mode_q  <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      if (ready_o) valid_q <= valid_i;
      if (pop) begin
        phase_q      <= phase_d;
        hdr_cnt_q    <= hdr_cnt_d;
        hdr_count_q  <= hdr_count_d;
        hdr_total_q  <= hdr_total_d;
        name_len_q   <= name_len_d;
        mark_match_q <= mark_match_d;
        size_cnt_q   <= size_cnt_d;
        size_q       <= size_d;
        remain_q     <= remain_d;
        rx_total_q   <= rx_total_d;
        elem_cnt_q   <= elem_cnt_d;
        kind_q       <= kind_d;
        file_open_q  <= file_open_d;
        text_mode_q  <= text_mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) out_q <= out_d;
  end

  assign valid_o = valid_q;
  assign item_o  = out_q;

endmodule

FILE: hw/rtl/file_transfer_stream_deframer.sv
// Channel   Direction  Payload                          Handshake
// in_i      sink       kind, byte_value                 valid/ready
// out_o     source     byte_class ... error_flag        valid/ready
//
// One word per cycle sustained while results are taken; each word gives
// exactly one result word. An accepted word is held in the front register,
// then the two-entry queue and then the parser output register.
// Reset is asynchronous and active low and puts the parser in its idle phase.
// The front end and the parser stall independently through the queue; a
// stalled result register holds while the queue and front accept until full.
// Top level of the file transfer stream deframer. Depends on ftsd_pkg,
// ftsd_stream_if, ftsd_front, ftsd_queue and ftsd_back.

module file_transfer_stream_deframer #(
  parameter int unsigned MAX_NAME_BYTES = ftsd_pkg::MaxNameBytesDefault,
  parameter int unsigned INDEX_WIDTH    = ftsd_pkg::IndexWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ftsd_stream_if.sink   in_i,
  ftsd_stream_if.source out_o
);

  logic               front_valid;
  logic               front_ready;
  ftsd_pkg::op_item_t front_item;
  logic               queue_valid;
  logic               queue_ready;
  ftsd_pkg::op_item_t queue_item;
  ftsd_pkg::in_item_t in_item;
  ftsd_pkg::out_item_t out_item;

  assign in_item = in_i.payload;

  ftsd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .item_o  (front_item)
  );

  ftsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  ftsd_back #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES),
    .INDEX_WIDTH    (INDEX_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .ready_o (queue_ready),
    .item_i  (queue_item),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .item_o  (out_item)
  );

  assign out_o.payload = out_item;

endmodule

FILE: bench/tb_file_transfer_stream_deframer.sv
// Self-checking bench for the file transfer stream deframer. It has a driver fed from a queue,
// a result monitor and a behavioural model of the parser that predicts every result word.
// Depends on ftsd_pkg, ftsd_stream_if and the deframer RTL.

module tb_file_transfer_stream_deframer;
  import ftsd_pkg::*;

  localparam int unsigned NameLimit = MaxNameBytesDefault;
  localparam int unsigned RandomWords = 1650;
  // The text marker name, first character in the top byte.
  localparam logic [8*MarkLen-1:0] TextMark = 144'h5F5F5F44554B544F5F5F5F544558545F5F5F;
  localparam logic [63:0] SizeFolder = '1;
  localparam logic [63:0] RxSaturate = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum int {
    EL_FILE, EL_TEXT, EL_FOLDER, EL_EMPTY, EL_NEAR_MARK, EL_NO_NAME,
    EL_BAD_SIZE, EL_LONG_NAME, EL_LIMIT_NAME
  } elem_plan_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ftsd_stream_if #(.payload_t(in_item_t))  words_in ();
  ftsd_stream_if #(.payload_t(out_item_t)) results_out ();

  file_transfer_stream_deframer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (words_in),
    .out_o  (results_out)
  );

  always #6 clk_i = ~clk_i;

  in_item_t  pending[$];
  in_item_t  burst[$];
  out_item_t parsed_words[$];
  int        accepted_words = 0;
  int        checked_words = 0;
  int        total_words = 0;
  int        mismatches = 0;
  bit        hold_off = 1'b0;

  // Parser state kept by the predictor.
  phase_e      ph;
  int          hdr_cnt;
  logic [63:0] hdr_elems;
  logic [63:0] hdr_bytes;
  int          name_len;
  bit          mark_ok;
  int          size_cnt;
  logic [63:0] size_acc;
  logic [63:0] left_bytes;
  logic [63:0] data_seen;
  logic [15:0] elem_idx;
  elem_kind_e  cur_kind;
  bit          file_partial;
  bit          last_was_text;

  function automatic logic [7:0] text_char(input int pos);
    return TextMark[8*(MarkLen-1-pos) +: 8];
  endfunction

  function automatic void clear_parser();
    ph = PH_IDLE;
    hdr_cnt = 0;
    hdr_elems = '0;
    hdr_bytes = '0;
    name_len = 0;
    mark_ok = 1'b1;
    size_cnt = 0;
    size_acc = '0;
    left_bytes = '0;
    data_seen = '0;
    elem_idx = '0;
    cur_kind = EK_FOLDER;
    file_partial = 1'b0;
    last_was_text = 1'b0;
  endfunction

  function automatic out_item_t parse_word(input in_item_t w);
    out_item_t   r;
    logic [7:0]  b;
    logic [15:0] idx;
    bit          shut;
    bit          is_text;
    r = '0;
    b = w.byte_value;
    shut = 1'b0;
    idx = elem_idx;
    r.byte_class = CLS_IGNORED;
    r.close_status = CS_NONE;
    case (w.kind)
      KIND_OPEN: begin
        clear_parser();
        ph = PH_HEADER;
        r.byte_class = CLS_EVENT;
        idx = elem_idx;
      end
      KIND_CLOSE: begin
        r.byte_class = CLS_EVENT;
        if (ph == PH_IDLE) r.close_status = CS_NONE;
        else if (ph == PH_ERROR || file_partial) r.close_status = CS_CANCELLED;
        else if (last_was_text) r.close_status = CS_TEXT;
        else r.close_status = CS_COMPLETE;
        shut = 1'b1;
      end
      KIND_DATA: begin
        case (ph)
          PH_HEADER: begin
            r.byte_class = CLS_HEADER;
            if (hdr_cnt < 8) hdr_elems |= 64'(b) << (8 * hdr_cnt);
            else hdr_bytes |= 64'(b) << (8 * ((hdr_cnt - 8) & 7));
            hdr_cnt++;
            if (hdr_cnt >= 16) begin
              ph = PH_NAME;
              name_len = 0;
              mark_ok = 1'b1;
            end
          end
          PH_NAME: begin
            if (b == 8'h00) begin
              r.byte_class = CLS_NAME_END;
              if (!(mark_ok && name_len == MarkLen)) mark_ok = 1'b0;
              ph = PH_SIZE;
              size_cnt = 0;
              size_acc = '0;
            end else if (name_len >= NameLimit) begin
              r.error_flag = 1'b1;
              ph = PH_ERROR;
            end else begin
              r.byte_class = CLS_NAME;
              if (name_len >= MarkLen || text_char(name_len) != b) mark_ok = 1'b0;
              name_len++;
            end
          end
          PH_SIZE: begin
            r.byte_class = CLS_SIZE;
            size_acc |= 64'(b) << (8 * (size_cnt & 7));
            size_cnt++;
            if (size_cnt >= 8) begin
              is_text = mark_ok && name_len == MarkLen;
              name_len = 0;
              mark_ok = 1'b1;
              if (size_acc == SizeFolder) begin
                cur_kind = EK_FOLDER;
                r.element_done = 1'b1;
                elem_idx++;
                ph = PH_NAME;
              end else if (size_acc[63]) begin
                r.error_flag = 1'b1;
                ph = PH_ERROR;
              end else begin
                cur_kind = is_text ? EK_TEXT : EK_FILE;
                last_was_text = is_text;
                if (size_acc == '0) begin
                  file_partial = 1'b0;
                  r.element_done = 1'b1;
                  elem_idx++;
                  ph = PH_NAME;
                end else begin
                  file_partial = !is_text;
                  left_bytes = size_acc;
                  ph = PH_DATA;
                end
              end
            end
          end
          PH_DATA: begin
            r.byte_class = CLS_DATA;
            if (data_seen < RxSaturate) data_seen++;
            if (left_bytes != '0) left_bytes--;
            if (left_bytes == '0) begin
              r.element_done = 1'b1;
              file_partial = 1'b0;
              elem_idx++;
              ph = PH_NAME;
              name_len = 0;
              mark_ok = 1'b1;
            end
          end
          default: r.byte_class = CLS_IGNORED;
        endcase
      end
      default: r.byte_class = CLS_IGNORED;
    endcase
    r.byte_out = b;
    r.element_index = idx;
    r.element_kind = cur_kind;
    r.element_size = size_acc;
    r.announced_count = hdr_elems[62:0];
    r.announced_total = hdr_bytes[62:0];
    r.received_total = data_seen[62:0];
    if (shut) clear_parser();
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_word(input logic [1:0] k, input logic [7:0] v);
    burst.push_back(in_item_t'{k, v});
  endtask

  task automatic add_le64(input logic [63:0] v);
    for (int i = 0; i < 8; i++) add_word(KIND_DATA, v[8*i +: 8]);
  endtask

  task automatic add_name(input int len);
    for (int i = 0; i < len; i++) add_word(KIND_DATA, 8'($urandom_range(1, 255)));
  endtask

  task automatic add_data(input logic [63:0] n);
    for (int i = 0; i < int'(n); i++) add_word(KIND_DATA, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [63:0] pick_size();
    if ($urandom_range(0, 99) < 85) return 64'($urandom_range(1, 24));
    return 64'($urandom_range(25, 120));
  endfunction

  function automatic elem_plan_e random_plan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return EL_FILE;
    if (r < 50) return EL_TEXT;
    if (r < 62) return EL_FOLDER;
    if (r < 72) return EL_EMPTY;
    if (r < 82) return EL_NEAR_MARK;
    if (r < 90) return EL_NO_NAME;
    if (r < 98) return EL_BAD_SIZE;
    if (r < 99) return EL_LONG_NAME;
    return EL_LIMIT_NAME;
  endfunction

  task automatic add_element(input elem_plan_e plan, output bit broken);
    logic [63:0] sz;
    logic [7:0]  c;
    int          spot;
    int          variant;
    broken = 1'b0;
    case (plan)
      EL_FILE: begin
        add_name($urandom_range(1, 10));
        add_word(KIND_DATA, 8'h00);
        sz = pick_size();
        add_le64(sz);
        add_data(sz);
      end
      EL_TEXT: begin
        for (int i = 0; i < MarkLen; i++) add_word(KIND_DATA, text_char(i));
        add_word(KIND_DATA, 8'h00);
        sz = ($urandom_range(0, 3) == 0) ? '0 : 64'($urandom_range(1, 16));
        add_le64(sz);
        add_data(sz);
      end
      EL_FOLDER: begin
        add_name($urandom_range(0, 6));
        add_word(KIND_DATA, 8'h00);
        add_le64(SizeFolder);
      end
      EL_EMPTY: begin
        add_name($urandom_range(1, 8));
        add_word(KIND_DATA, 8'h00);
        add_le64('0);
      end
      EL_NEAR_MARK: begin
        // Almost the marker: one character altered, one short or one extra.
        variant = $urandom_range(0, 2);
        spot = $urandom_range(0, MarkLen - 1);
        for (int i = 0; i < MarkLen; i++) begin
          c = text_char(i);
          if (variant == 0 && i == spot) c = c ^ 8'($urandom_range(1, 255));
          if (c == 8'h00) c = 8'h01;
          if (!(variant == 1 && i == MarkLen - 1)) add_word(KIND_DATA, c);
        end
        if (variant == 2) add_word(KIND_DATA, 8'($urandom_range(1, 255)));
        add_word(KIND_DATA, 8'h00);
        sz = 64'($urandom_range(0, 8));
        add_le64(sz);
        add_data(sz);
      end
      EL_NO_NAME: begin
        add_word(KIND_DATA, 8'h00);
        sz = 64'($urandom_range(1, 6));
        add_le64(sz);
        add_data(sz);
      end
      EL_BAD_SIZE: begin
        add_name($urandom_range(1, 4));
        add_word(KIND_DATA, 8'h00);
        sz = {$urandom, $urandom};
        sz[63] = 1'b1;
        if ($urandom_range(0, 2) == 0 || sz == SizeFolder) sz = 64'hFFFF_FFFF_FFFF_FFFE;
        add_le64(sz);
        broken = 1'b1;
      end
      EL_LONG_NAME: begin
        add_name(NameLimit + $urandom_range(1, 3));
        broken = 1'b1;
      end
      default: begin
        // A name exactly at the length limit is still legal.
        add_name(NameLimit);
        add_word(KIND_DATA, 8'h00);
        sz = 64'($urandom_range(0, 3));
        add_le64(sz);
        add_data(sz);
      end
    endcase
  endtask

  task automatic queue_burst(input bit noisy);
    foreach (burst[i]) begin
      if (noisy && $urandom_range(0, 49) == 0)
        pending.push_back(in_item_t'{KIND_UNUSED, 8'($urandom_range(0, 255))});
      pending.push_back(burst[i]);
    end
    burst.delete();
  endtask

  task automatic add_transfer(input int serial);
    int         n_elem;
    int         cut;
    int         r;
    bit         broken;
    elem_plan_e plan;
    burst.delete();
    r = $urandom_range(0, 99);
    if (r < 5) add_word(KIND_DATA, 8'($urandom_range(0, 255)));
    else if (r < 10) add_word(KIND_CLOSE, 8'($urandom_range(0, 255)));
    add_word(KIND_OPEN, 8'($urandom_range(0, 255)));
    repeat (16) add_word(KIND_DATA, 8'($urandom_range(0, 255)));
    n_elem = $urandom_range(1, 4);
    broken = 1'b0;
    for (int i = 0; i < n_elem && !broken; i++) begin
      if (i == 0 && serial == 2) plan = EL_LONG_NAME;
      else if (i == 0 && serial == 5) plan = EL_LIMIT_NAME;
      else plan = random_plan();
      add_element(plan, broken);
    end
    if (broken) begin
      repeat ($urandom_range(1, 4)) add_word(KIND_DATA, 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 99) < 15) begin
      // Break the transfer off at an arbitrary word.
      cut = $urandom_range(1, burst.size() - 1);
      burst = burst[0:cut-1];
    end
    if ($urandom_range(0, 99) < 80) add_word(KIND_CLOSE, 8'($urandom_range(0, 255)));
    queue_burst(1'b1);
  endtask

  function automatic int pick_pause(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch on result word %0d: %s got %h expected %h",
               checked_words, what, got, want);
  endtask

  // ---------------------------------------------------------------- driver

  int gap_left = 0;
  bit tx_quiet = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      words_in.valid <= 1'b0;
      words_in.payload <= '0;
    end else begin
      if (words_in.valid && words_in.ready) begin
        parsed_words.push_back(parse_word(words_in.payload));
        accepted_words++;
      end
      if ($urandom_range(0, 199) == 0) tx_quiet = !tx_quiet;
      if (words_in.valid && !words_in.ready) begin
        // Hold the offered word until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        words_in.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        words_in.payload <= pending.pop_front();
        words_in.valid <= 1'b1;
        gap_left = pick_pause(tx_quiet);
      end else begin
        words_in.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int stall_left = 0;
  bit rx_quiet = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      results_out.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
      if (hold_off) begin
        results_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        results_out.ready <= 1'b0;
      end else begin
        results_out.ready <= 1'b1;
        stall_left = pick_pause(rx_quiet);
      end
    end
  end

  // Long hold-offs while the sender keeps offering, so the block backs up.
  initial begin : pressure
    int mark;
    mark = 300;
    repeat (2) begin
      while (accepted_words < mark) @(posedge clk_i);
      hold_off <= 1'b1;
      repeat (250) @(posedge clk_i);
      hold_off <= 1'b0;
      mark = 1100;
    end
  end

  always @(posedge clk_i) begin : monitor
    out_item_t got;
    out_item_t want;
    if (rst_ni && results_out.valid && results_out.ready) begin
      got = results_out.payload;
      if (parsed_words.size() == 0) begin
        flag_mismatch("result with nothing outstanding", 64'(got.byte_out), '0);
      end else begin
        want = parsed_words.pop_front();
        if (got.byte_class !== want.byte_class)
          flag_mismatch("byte_class", 64'(got.byte_class), 64'(want.byte_class));
        if (got.byte_out !== want.byte_out)
          flag_mismatch("byte_out", 64'(got.byte_out), 64'(want.byte_out));
        if (got.element_index !== want.element_index)
          flag_mismatch("element_index", 64'(got.element_index), 64'(want.element_index));
        if (got.element_kind !== want.element_kind)
          flag_mismatch("element_kind", 64'(got.element_kind), 64'(want.element_kind));
        if (got.element_size !== want.element_size)
          flag_mismatch("element_size", got.element_size, want.element_size);
        if (got.element_done !== want.element_done)
          flag_mismatch("element_done", 64'(got.element_done), 64'(want.element_done));
        if (got.announced_count !== want.announced_count)
          flag_mismatch("announced_count", 64'(got.announced_count),
                        64'(want.announced_count));
        if (got.announced_total !== want.announced_total)
          flag_mismatch("announced_total", 64'(got.announced_total),
                        64'(want.announced_total));
        if (got.received_total !== want.received_total)
          flag_mismatch("received_total", 64'(got.received_total), 64'(want.received_total));
        if (got.close_status !== want.close_status)
          flag_mismatch("close_status", 64'(got.close_status), 64'(want.close_status));
        if (got.error_flag !== want.error_flag)
          flag_mismatch("error_flag", 64'(got.error_flag), 64'(want.error_flag));
      end
      checked_words++;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int serial;
    int goal;
    rst_ni = 1'b0;
    words_in.valid = 1'b0;
    words_in.payload = '0;
    results_out.ready = 1'b0;
    clear_parser();

    // Directed start: unused kind, a stray word and a close while idle, then a header with
    // the top bit of the count set and an all-ones total, and a nameless folder.
    add_word(KIND_UNUSED, 8'hFF);
    add_word(KIND_DATA, 8'hA5);
    add_word(KIND_CLOSE, 8'h5A);
    add_word(KIND_OPEN, 8'h00);
    add_le64(64'h8000_0000_0000_0003);
    add_le64(SizeFolder);
    add_word(KIND_DATA, 8'h00);
    add_le64(SizeFolder);
    add_word(KIND_CLOSE, 8'hFF);
    queue_burst(1'b0);

    serial = 0;
    goal = pending.size() + RandomWords;
    while (pending.size() < goal) begin
      add_transfer(serial);
      serial++;
    end
    total_words = pending.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_words < total_words) @(posedge clk_i);
    while (parsed_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("file_transfer_stream_deframer regression: pass");
    end else begin
      $display("file_transfer_stream_deframer regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #24_000_000;
    $display("file_transfer_stream_deframer regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ftsd_pkg.sv
hw/rtl/ftsd_stream_if.sv
hw/rtl/ftsd_front.sv
hw/rtl/ftsd_queue.sv
hw/rtl/ftsd_back.sv
hw/rtl/file_transfer_stream_deframer.sv
bench/tb_file_transfer_stream_deframer.sv
